// ===== sv/relocation_delta_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Relocation delta encoder assertion macros
// Shared assertion forms for the port checker of the relocation delta encoder.
// ----------------------------------------------------------------------------
`ifndef RELOCATION_DELTA_ENCODER_ASSERT_SVH
`define RELOCATION_DELTA_ENCODER_ASSERT_SVH

// Checked only while the block is out of reset.
`define RDE_ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("relocation_delta_encoder: run-time check failed");

// Checked at every edge, reset included.
`define RDE_ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("relocation_delta_encoder: reset check failed");

`endif

// ===== sv/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// Relocation delta encoder package
// Queue entry type and coding constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam logic signed [32:0] SHORT2_LIMIT = 33'sd4000;
    localparam logic signed [32:0] SHORT3_LIMIT = 33'sd510000;
    localparam logic signed [31:0] OFFSET_MIN   = -32'sd1;
    localparam logic signed [31:0] OFFSET_MAX   = 32'sh3fff_fffe;

    localparam logic       TAG_SHORT2 = 1'b1;
    localparam logic [1:0] TAG_SHORT3 = 2'b01;
    localparam logic [1:0] TAG_ABS    = 2'b00;

    localparam logic [2:0] LAST_ERROR  = 3'd0;
    localparam logic [2:0] LAST_SHORT2 = 3'd1;
    localparam logic [2:0] LAST_SHORT3 = 3'd2;
    localparam logic [2:0] LAST_ABS    = 3'd7;

    // One coded entry: bytes are sent from the top of the word downward.
    typedef struct packed {
        logic [63:0] bytes;
        logic [2:0]  last_idx;
        logic        err;
    } t_entry;

endpackage

// ===== sv/rde_fifo.sv =====
// ----------------------------------------------------------------------------
// Relocation delta encoder queue
// Small first-word-fall-through queue of coded entries between front and back.
// ----------------------------------------------------------------------------
module rde_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rde_pkg::t_entry i_push_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output rde_pkg::t_entry o_pop_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rde_pkg::t_entry r_slot [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_empty     = (r_count == '0);
    assign o_pop_entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// ===== sv/rde_front.sv =====
// ----------------------------------------------------------------------------
// Relocation delta encoder front end
// Accepts entries, compares them with the previous entry and builds the code.
// ----------------------------------------------------------------------------
module rde_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_offset,
    input  logic [31:0]     i_contents,
    input  logic            i_full,
    output logic            o_push,
    output rde_pkg::t_entry o_entry
);

    logic [31:0]        r_prev_offset;
    logic [31:0]        r_prev_contents;
    logic signed [32:0] d_offs;
    logic signed [32:0] d_cont;
    logic               step_ok;
    logic               fits2;
    logic               fits3;
    logic               off_ok;
    logic [1:0]         ss;
    logic               update;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign d_offs = $signed({i_offset[31], i_offset})
                  - $signed({r_prev_offset[31], r_prev_offset});
    assign d_cont = $signed({1'b0, i_contents}) - $signed({1'b0, r_prev_contents});

    assign step_ok = (d_offs[32:5] == '0) && (d_offs[1:0] == 2'b00)
                  && (d_offs[4:2] != 3'd0) && (d_offs[4:2] <= 3'd4);
    assign ss      = d_offs[3:2] - 2'd1;
    assign fits2   = (d_cont < rde_pkg::SHORT2_LIMIT) && (d_cont > -rde_pkg::SHORT2_LIMIT);
    assign fits3   = (d_cont < rde_pkg::SHORT3_LIMIT) && (d_cont > -rde_pkg::SHORT3_LIMIT);
    assign off_ok  = ($signed(i_offset) >= rde_pkg::OFFSET_MIN)
                  && ($signed(i_offset) <= rde_pkg::OFFSET_MAX);

    always_comb begin
        o_entry = '0;
        update  = 1'b1;
        priority if (step_ok && fits2) begin
            o_entry.bytes    = {rde_pkg::TAG_SHORT2, ss, d_cont[12:0], 48'd0};
            o_entry.last_idx = rde_pkg::LAST_SHORT2;
        end else if (step_ok && fits3) begin
            o_entry.bytes    = {rde_pkg::TAG_SHORT3, ss, d_cont[19:0], 40'd0};
            o_entry.last_idx = rde_pkg::LAST_SHORT3;
        end else if (off_ok) begin
            o_entry.bytes    = {rde_pkg::TAG_ABS, i_offset[29:0], i_contents};
            o_entry.last_idx = rde_pkg::LAST_ABS;
        end else begin
            o_entry.bytes    = '0;
            o_entry.last_idx = rde_pkg::LAST_ERROR;
            o_entry.err      = 1'b1;
            update           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_offset   <= '0;
            r_prev_contents <= '0;
        end else if (o_push && update) begin
            r_prev_offset   <= i_offset;
            r_prev_contents <= i_contents;
        end
    end

endmodule

// ===== sv/rde_back.sv =====
// ----------------------------------------------------------------------------
// Relocation delta encoder back end
// Takes coded entries from the queue and sends them one byte per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module rde_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  rde_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_last,
    output logic            o_error
);

    logic        r_busy, n_busy;
    logic [63:0] r_word, n_word;
    logic [2:0]  r_left, n_left;
    logic        r_err, n_err;
    logic        out_fire;
    logic        need_load;

    assign o_valid = r_busy;
    assign o_data  = r_word[63:56];
    assign o_last  = (r_left == 3'd0);
    assign o_error = r_err;

    assign out_fire  = r_busy && i_ready;
    assign need_load = !r_busy || (out_fire && (r_left == 3'd0));
    assign o_pop     = need_load && !i_empty;

    always_comb begin
        n_busy = r_busy;
        n_word = r_word;
        n_left = r_left;
        n_err  = r_err;
        if (o_pop) begin
            n_busy = 1'b1;
            n_word = i_entry.bytes;
            n_left = i_entry.last_idx;
            n_err  = i_entry.err;
        end else if (need_load) begin
            n_busy = 1'b0;
        end else if (out_fire) begin
            n_word = {r_word[55:0], 8'd0};
            n_left = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_err  <= n_err;
    end

endmodule

// ===== sv/relocation_delta_encoder.sv =====
// ----------------------------------------------------------------------------
// Relocation delta encoder
// Codes relocation entries relative to the previous entry as a byte stream.
// ----------------------------------------------------------------------------
// The slave channel takes one item per entry: offset in tdata[31:0] and the
// contents word in tdata[63:32]. The master channel sends the code one byte
// per item, most significant first, with tlast on the final byte and tuser
// high on the single zero byte sent for an offset that cannot be coded.
// A 2-byte code sends 2 bytes, a 3-byte code 3, an absolute code 8 and
// the error item 1. The front end keeps accepting entries into a
// QUEUE_DEPTH-entry queue while bytes go out. When the queue and the back
// end are idle, an accepted entry is written into the queue, then loaded
// into the back end register, which presents its first byte.
// Reset clears the previous offset and contents to zero and empties the
// queue. When the receiver stalls, the current byte holds; the slave side
// keeps accepting until the queue is full, then drops tready.
// ----------------------------------------------------------------------------
module relocation_delta_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // offset[31:0], contents[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser   // error
);

    rde_pkg::t_entry push_entry;
    rde_pkg::t_entry pop_entry;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    rde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_offset   (s_axis_tdata[31:0]),
        .i_contents (s_axis_tdata[63:32]),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    rde_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_pop_entry  (pop_entry)
    );

    rde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_error (m_axis_tuser)
    );

endmodule

// ===== sv/rde_checker.sv =====
// ----------------------------------------------------------------------------
// Relocation delta encoder port checker
// Checks the encoder's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "relocation_delta_encoder_assert.svh"

module rde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    logic in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    `RDE_ASSERT_ANY(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `RDE_ASSERT_RUN(a_error_item, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    `RDE_ASSERT_RUN(a_code_unbroken, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    `RDE_ASSERT_RUN(a_stall_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    `RDE_ASSERT_RUN(a_first_out_after_in, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> $past(in_fire) || $past(in_fire, 2) || !$past(i_rst_n, 2))

endmodule

bind relocation_delta_encoder rde_checker u_rde_checker (.*);
